// ----- rtl/sphlb_pkg.sv -----
// Package: types and constants for the SPI packet header and length budget block.
`timescale 1ns / 1ps

package sphlb_pkg;

  // Padding cap, header marker and header size in bytes
  localparam logic [15:0] PAD_BYTES = 16'd16384;
  localparam logic [15:0] SYNC_MARK = 16'hCAFE;
  localparam logic [15:0] HDR_BYTES = 16'd8;

  // Register widths and reset values
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned MISS_W     = 14;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_FIRST_RST  = 15'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_SECOND_RST = 15'd20480;
  localparam logic [MISS_W-1:0]  MISS_LIMIT_RST   = 14'd10000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT   = 2'd2;

  // Request codes
  localparam logic [1:0] REQ_OPEN   = 2'd0;
  localparam logic [1:0] REQ_HEADER = 2'd1;
  localparam logic [1:0] REQ_XFER   = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OPENED   = 3'd0;
  localparam logic [2:0] ST_TAKEN    = 3'd1;
  localparam logic [2:0] ST_HDR_OK   = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_SYNC_ERR = 3'd4;
  localparam logic [2:0] ST_GRANTED  = 3'd5;
  localparam logic [2:0] ST_CLAMPED  = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        target;
    logic [7:0]  expected_code;
    logic        any_code;
    logic [15:0] header_word;
    logic [15:0] xfer_count;
    logic        xfer_rest;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pad_count;
    logic [15:0] grant_count;
    logic [15:0] remaining;
    logic        unlimited;
    logic [7:0]  atn_code;
    logic        limit_hit;
  } rsp_t;

endpackage

// ----- rtl/spi_packet_header_and_length_budget.sv -----
// Top level: header sync, attention code check and byte budget for framed SPI packets.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------
//   request | in        | in_valid_i, in_stall_o | in_data_i (req_t)
//   result  | out       | out_valid_o, out_stall_i | out_data_o (rsp_t)
//   config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// The state update and the result are formed in the accepting cycle and the
// result sits in the output register in the cycle after.
// One beat per cycle is sustained while the result side takes beats.
// Reset puts the header tracker idle with no budget in force and loads the
// register defaults. A stalled result holds; a new beat is taken only when the
// output register is empty or being emptied in the same cycle.
`timescale 1ns / 1ps

module spi_packet_header_and_length_budget (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sphlb_pkg::req_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output sphlb_pkg::rsp_t                      out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [sphlb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sphlb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT,
    PH_CODE,
    PH_TX,
    PH_RX
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [sphlb_pkg::MISS_W-1:0]      miss_q, miss_d;
  logic [15:0]                       budget_q, budget_d;
  logic                              off_q, off_d;
  logic                              tgt_q, tgt_d;
  logic [7:0]                        want_q, want_d;
  logic                              any_q, any_d;
  logic [7:0]                        got_q, got_d;
  logic [15:0]                       txw_q, txw_d;

  logic [sphlb_pkg::LIMIT_W-1:0]     lim_first_q, lim_second_q;
  logic [sphlb_pkg::MISS_W-1:0]      miss_lim_q;

  logic                              out_valid_q;
  sphlb_pkg::rsp_t                   out_q, rsp_d;
  logic                              in_acc;

  logic [sphlb_pkg::LIMIT_W-1:0]     lim;
  logic [15:0]                       lim_ext;
  logic [sphlb_pkg::LIMIT_W-1:0]     tx_cl, rx_cl;
  logic [15:0]                       tx_b2, rx_b2, tx_bytes, rx_bytes;
  logic [sphlb_pkg::MISS_W-1:0]      miss_inc;
  logic [15:0]                       cnt_eff;

  // Take a beat when the output register is free or drains this cycle
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Clamp header lengths to the selected target's limit and convert to bytes
  assign lim      = tgt_q ? lim_second_q : lim_first_q;
  assign lim_ext  = {1'b0, lim};
  assign tx_cl    = (txw_q > lim_ext) ? lim : txw_q[sphlb_pkg::LIMIT_W-1:0];
  assign rx_cl    = (in_data_i.header_word > lim_ext) ? lim
                    : in_data_i.header_word[sphlb_pkg::LIMIT_W-1:0];
  assign tx_b2    = {tx_cl, 1'b0};
  assign rx_b2    = {rx_cl, 1'b0};
  assign tx_bytes = (tx_b2 >= sphlb_pkg::HDR_BYTES) ? tx_b2 - sphlb_pkg::HDR_BYTES : 16'd0;
  assign rx_bytes = (rx_b2 >= sphlb_pkg::HDR_BYTES) ? rx_b2 - sphlb_pkg::HDR_BYTES : 16'd0;
  assign miss_inc = miss_q + 1'b1;
  assign cnt_eff  = in_data_i.xfer_rest ? budget_q : in_data_i.xfer_count;

  // Work out the next state and the result of the current beat
  always_comb begin
    phase_d  = phase_q;
    miss_d   = miss_q;
    budget_d = budget_q;
    off_d    = off_q;
    tgt_d    = tgt_q;
    want_d   = want_q;
    any_d    = any_q;
    got_d    = got_q;
    txw_d    = txw_q;
    rsp_d    = '0;
    rsp_d.status = sphlb_pkg::ST_TAKEN;
    case (in_data_i.req_type)
      sphlb_pkg::REQ_OPEN: begin
        if (!off_q && budget_q != 16'd0) begin
          rsp_d.pad_count = (budget_q < sphlb_pkg::PAD_BYTES) ? budget_q
                            : sphlb_pkg::PAD_BYTES;
        end
        off_d    = 1'b1;
        budget_d = '0;
        tgt_d    = in_data_i.target;
        want_d   = in_data_i.expected_code;
        any_d    = in_data_i.any_code;
        got_d    = '0;
        miss_d   = '0;
        phase_d  = PH_HUNT;
        rsp_d.status = sphlb_pkg::ST_OPENED;
      end
      sphlb_pkg::REQ_HEADER: begin
        unique case (phase_q)
          PH_HUNT: begin
            if (in_data_i.header_word == sphlb_pkg::SYNC_MARK) begin
              phase_d = PH_CODE;
            end else begin
              miss_d = miss_inc;
              if (miss_inc >= miss_lim_q) begin
                phase_d = PH_IDLE;
                rsp_d.status = sphlb_pkg::ST_SYNC_ERR;
              end
            end
          end
          PH_CODE: begin
            got_d   = in_data_i.header_word[7:0];
            phase_d = PH_TX;
          end
          PH_TX: begin
            txw_d   = in_data_i.header_word;
            phase_d = PH_RX;
          end
          PH_RX: begin
            rsp_d.limit_hit = (txw_q > lim_ext) || (in_data_i.header_word > lim_ext);
            budget_d = (tx_bytes >= rx_bytes) ? tx_bytes : rx_bytes;
            off_d    = 1'b0;
            phase_d  = PH_IDLE;
            rsp_d.status = (any_q || got_q == want_q) ? sphlb_pkg::ST_HDR_OK
                           : sphlb_pkg::ST_MISMATCH;
          end
          default: begin
            // Idle: drop the word
          end
        endcase
      end
      sphlb_pkg::REQ_XFER: begin
        rsp_d.status = sphlb_pkg::ST_GRANTED;
        if (off_q) begin
          rsp_d.grant_count = in_data_i.xfer_rest ? 16'd0 : in_data_i.xfer_count;
        end else if (cnt_eff > budget_q) begin
          rsp_d.grant_count = budget_q;
          budget_d = '0;
          rsp_d.status = sphlb_pkg::ST_CLAMPED;
        end else begin
          rsp_d.grant_count = cnt_eff;
          budget_d = budget_q - cnt_eff;
        end
      end
      default: begin
        // Unknown request: report word taken, change nothing
      end
    endcase
    rsp_d.remaining = off_d ? 16'd0 : budget_d;
    rsp_d.unlimited = off_d;
    rsp_d.atn_code  = got_d;
  end

  // Hold the tracker state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      miss_q      <= '0;
      budget_q    <= '0;
      off_q       <= 1'b1;
      tgt_q       <= 1'b0;
      want_q      <= '0;
      any_q       <= 1'b0;
      got_q       <= '0;
      txw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q  <= phase_d;
        miss_q   <= miss_d;
        budget_q <= budget_d;
        off_q    <= off_d;
        tgt_q    <= tgt_d;
        want_q   <= want_d;
        any_q    <= any_d;
        got_q    <= got_d;
        txw_q    <= txw_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= rsp_d;
    end
  end

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_first_q  <= sphlb_pkg::LIMIT_FIRST_RST;
      lim_second_q <= sphlb_pkg::LIMIT_SECOND_RST;
      miss_lim_q   <= sphlb_pkg::MISS_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sphlb_pkg::REG_LIMIT_FIRST:  lim_first_q  <= cfg_data_i[sphlb_pkg::LIMIT_W-1:0];
        sphlb_pkg::REG_LIMIT_SECOND: lim_second_q <= cfg_data_i[sphlb_pkg::LIMIT_W-1:0];
        sphlb_pkg::REG_MISS_LIMIT:   miss_lim_q   <= cfg_data_i[sphlb_pkg::MISS_W-1:0];
        default: begin
          // Unmapped index: ignore the write
        end
      endcase
    end
  end

  // No budget is in force while a header is being parsed
  a_hdr_unlimited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> off_q)
    else $error("budget in force during header parse");

  // An unlimited budget carries no bytes
  a_off_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q |-> (budget_q == 16'd0))
    else $error("budget bytes left while unlimited");

  // An open starts the marker hunt
  a_open_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.req_type == sphlb_pkg::REQ_OPEN) |=> (phase_q == PH_HUNT))
    else $error("open did not start marker hunt");

  // Every accepted beat yields a result
  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

// ----- tb/sphlb_tb_pkg.sv -----
// Scoreboard for the SPI packet header and length budget testbench: predictor and result checks.
`timescale 1ns / 1ps

package sphlb_tb_pkg;

  typedef enum logic [2:0] {
    HDR_IDLE,
    HDR_HUNT,
    HDR_CODE,
    HDR_TX,
    HDR_RX
  } hdr_phase_e;

  class budget_scoreboard;

    // Register copies
    logic [sphlb_pkg::LIMIT_W-1:0] limit_first;
    logic [sphlb_pkg::LIMIT_W-1:0] limit_second;
    logic [sphlb_pkg::MISS_W-1:0]  miss_limit;

    // Header tracker and budget state
    hdr_phase_e                    phase;
    logic [sphlb_pkg::MISS_W-1:0]  miss_count;
    logic [15:0]                   budget;
    logic                          budget_off;
    logic                          target;
    logic [7:0]                    wanted_code;
    logic [7:0]                    got_code;
    logic                          any_flag;
    logic [15:0]                   tx_words;

    sphlb_pkg::rsp_t               expected_q[$];
    int unsigned                   errors;
    int unsigned                   beats_checked;

    function new();
      limit_first   = sphlb_pkg::LIMIT_FIRST_RST;
      limit_second  = sphlb_pkg::LIMIT_SECOND_RST;
      miss_limit    = sphlb_pkg::MISS_LIMIT_RST;
      phase         = HDR_IDLE;
      miss_count    = '0;
      budget        = '0;
      budget_off    = 1'b1;
      target        = 1'b0;
      wanted_code   = '0;
      got_code      = '0;
      any_flag      = 1'b0;
      tx_words      = '0;
      errors        = 0;
      beats_checked = 0;
    endfunction

    // Print one line per mismatch and count it
    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [sphlb_pkg::CFG_IDX_W-1:0] idx,
                            logic [sphlb_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sphlb_pkg::REG_LIMIT_FIRST:  limit_first  = data[sphlb_pkg::LIMIT_W-1:0];
        sphlb_pkg::REG_LIMIT_SECOND: limit_second = data[sphlb_pkg::LIMIT_W-1:0];
        sphlb_pkg::REG_MISS_LIMIT:   miss_limit   = data[sphlb_pkg::MISS_W-1:0];
        default: ;
      endcase
    endfunction

    // Header length in words to byte budget, floored at zero
    function logic [15:0] words_to_bytes(logic [15:0] words);
      int unsigned b;
      b = 2 * words;
      return (b >= sphlb_pkg::HDR_BYTES) ? 16'(b - sphlb_pkg::HDR_BYTES) : 16'd0;
    endfunction

    // Advance the state by one request beat and queue the result it causes
    function void note_request(sphlb_pkg::req_t r);
      sphlb_pkg::rsp_t e;
      logic [15:0]     lim;
      logic [15:0]     tx;
      logic [15:0]     rx;
      logic [15:0]     tx_b;
      logic [15:0]     rx_b;
      logic [15:0]     cnt;
      e        = '0;
      e.status = sphlb_pkg::ST_TAKEN;
      case (r.req_type)
        sphlb_pkg::REQ_OPEN: begin
          if (!budget_off && budget != 0)
            e.pad_count = (budget < sphlb_pkg::PAD_BYTES) ? budget : sphlb_pkg::PAD_BYTES;
          budget_off  = 1'b1;
          budget      = '0;
          target      = r.target;
          wanted_code = r.expected_code;
          any_flag    = r.any_code;
          got_code    = '0;
          miss_count  = '0;
          phase       = HDR_HUNT;
          e.status    = sphlb_pkg::ST_OPENED;
        end
        sphlb_pkg::REQ_HEADER: begin
          case (phase)
            HDR_HUNT: begin
              if (r.header_word == sphlb_pkg::SYNC_MARK) begin
                phase = HDR_CODE;
              end else begin
                miss_count = miss_count + 1'b1;
                if (miss_count >= miss_limit) begin
                  phase    = HDR_IDLE;
                  e.status = sphlb_pkg::ST_SYNC_ERR;
                end
              end
            end
            HDR_CODE: begin
              got_code = r.header_word[7:0];
              phase    = HDR_TX;
            end
            HDR_TX: begin
              tx_words = r.header_word;
              phase    = HDR_RX;
            end
            HDR_RX: begin
              lim = target ? 16'(limit_second) : 16'(limit_first);
              tx  = tx_words;
              rx  = r.header_word;
              if (tx > lim || rx > lim) e.limit_hit = 1'b1;
              if (tx > lim) tx = lim;
              if (rx > lim) rx = lim;
              tx_b       = words_to_bytes(tx);
              rx_b       = words_to_bytes(rx);
              budget     = (tx_b >= rx_b) ? tx_b : rx_b;
              budget_off = 1'b0;
              phase      = HDR_IDLE;
              e.status   = (any_flag || got_code == wanted_code) ? sphlb_pkg::ST_HDR_OK
                           : sphlb_pkg::ST_MISMATCH;
            end
            default: ;
          endcase
        end
        sphlb_pkg::REQ_XFER: begin
          e.status = sphlb_pkg::ST_GRANTED;
          cnt      = r.xfer_count;
          if (budget_off) begin
            e.grant_count = r.xfer_rest ? 16'd0 : cnt;
          end else begin
            if (r.xfer_rest) cnt = budget;
            if (cnt > budget) begin
              cnt      = budget;
              e.status = sphlb_pkg::ST_CLAMPED;
            end
            budget        = budget - cnt;
            e.grant_count = cnt;
          end
        end
        default: ;
      endcase
      e.remaining = budget_off ? 16'd0 : budget;
      e.unlimited = budget_off;
      e.atn_code  = got_code;
      expected_q.push_back(e);
    endfunction

    task compare_field(string field, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result beat %0d: %s is 0x%0h, expected 0x%0h",
                         beats_checked, field, got, want));
    endtask

    // Compare one result beat against the oldest expectation
    task check_result(sphlb_pkg::rsp_t got);
      sphlb_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", beats_checked));
      end else begin
        want = expected_q.pop_front();
        compare_field("status",      got.status,      want.status);
        compare_field("pad_count",   got.pad_count,   want.pad_count);
        compare_field("grant_count", got.grant_count, want.grant_count);
        compare_field("remaining",   got.remaining,   want.remaining);
        compare_field("unlimited",   got.unlimited,   want.unlimited);
        compare_field("atn_code",    got.atn_code,    want.atn_code);
        compare_field("limit_hit",   got.limit_hit,   want.limit_hit);
      end
      beats_checked++;
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected result beats never arrived", expected_q.size()));
    endtask

  endclass

endpackage

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, stimulus, stall pattern and checking of the budget block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned LONG_HOLD       = 150;

  // Request code the block does not define
  localparam logic [1:0]  REQ_UNUSED      = 2'd3;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 req_valid;
  logic                                 req_stall;
  sphlb_pkg::req_t                      req_beat;
  logic                                 rsp_valid;
  logic                                 rsp_stall;
  sphlb_pkg::rsp_t                      rsp_beat;
  logic                                 cfg_we;
  logic [sphlb_pkg::CFG_IDX_W-1:0]      cfg_idx;
  logic [sphlb_pkg::CFG_DATA_W-1:0]     cfg_data;

  sphlb_tb_pkg::budget_scoreboard       sb;
  int unsigned                          cycles;
  int unsigned                          items_sent;
  int unsigned                          burst_left;
  int unsigned                          max_gap;
  logic                                 hold_request;

  spi_packet_header_and_length_budget i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_beat),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on total run length
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spi_packet_header_and_length_budget: mismatch");
      $finish;
    end
  end

  // Note accepted requests and check accepted results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_valid && !req_stall) sb.note_request(req_beat);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_beat);
    end
  end

  // Result side stall pattern: segments of random mode, plus long holds on request
  initial begin : result_stall
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    rsp_stall = 1'b0;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(40, 1);
          mode     = $urandom_range(3, 0);
        end
        seg_left--;
        case (mode)
          0: rsp_stall = 1'b0;
          1: rsp_stall = ($urandom_range(3, 0) == 0);
          2: rsp_stall = ($urandom_range(3, 0) != 0);
          default: rsp_stall = ~rsp_stall;
        endcase
      end
    end
  end

  // Fill every field at random, then override what the request needs
  function automatic sphlb_pkg::req_t random_beat();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(sphlb_pkg::req_t)-1:0];
  endfunction

  function automatic sphlb_pkg::req_t open_beat(logic tgt, logic [7:0] code, logic any);
    sphlb_pkg::req_t r;
    r               = random_beat();
    r.req_type      = sphlb_pkg::REQ_OPEN;
    r.target        = tgt;
    r.expected_code = code;
    r.any_code      = any;
    return r;
  endfunction

  function automatic sphlb_pkg::req_t word_beat(logic [15:0] w);
    sphlb_pkg::req_t r;
    r             = random_beat();
    r.req_type    = sphlb_pkg::REQ_HEADER;
    r.header_word = w;
    return r;
  endfunction

  function automatic sphlb_pkg::req_t xfer_beat(logic [15:0] cnt, logic rest);
    sphlb_pkg::req_t r;
    r            = random_beat();
    r.req_type   = sphlb_pkg::REQ_XFER;
    r.xfer_count = cnt;
    r.xfer_rest  = rest;
    return r;
  endfunction

  function automatic sphlb_pkg::req_t unused_beat();
    sphlb_pkg::req_t r;
    r          = random_beat();
    r.req_type = REQ_UNUSED;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // Header length: around the header size, around the limit, below, above or anywhere
  function automatic logic [15:0] pick_length(int unsigned lim);
    case ($urandom_range(4, 0))
      0: return 16'($urandom_range(8, 0));
      1: return clamp16(int'(lim) + int'($urandom_range(4, 0)) - 2);
      2: return 16'($urandom());
      3: return 16'($urandom_range(lim, 0));
      default: return 16'($urandom_range(65535, lim + 1));
    endcase
  endfunction

  // Transfer size: small, on the budget edge, anywhere or within the budget
  function automatic logic [15:0] pick_count(int unsigned left);
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(32, 0));
      1: return clamp16(int'(left) + int'($urandom_range(2, 0)) - 1);
      2: return 16'($urandom());
      default: return 16'($urandom_range(left, 0));
    endcase
  endfunction

  // Offer one beat and hold it until taken; bursts end in random gaps
  task automatic send(sphlb_pkg::req_t r);
    if (burst_left == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(max_gap, 0)) @(negedge clk);
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    req_valid = 1'b1;
    req_beat  = r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    if (r.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic drain();
    req_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [sphlb_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = sphlb_pkg::CFG_DATA_W'(data);
    sb.write_reg(idx, sphlb_pkg::CFG_DATA_W'(data));
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // One framed packet: open, some misses, marker, sometimes a transfer, code, lengths, then transfers
  task automatic send_packet();
    logic [7:0]  code;
    logic        tgt;
    int unsigned lim;
    int unsigned misses;
    logic [15:0] w;
    tgt  = 1'($urandom());
    code = 8'($urandom());
    send(open_beat(tgt, code, $urandom_range(3, 0) == 0));
    lim = tgt ? sb.limit_second : sb.limit_first;
    if (sb.miss_limit <= 16 && $urandom_range(4, 0) == 0)
      misses = $urandom_range(sb.miss_limit + 1, 0);
    else
      misses = $urandom_range(3, 0);
    repeat (misses) begin
      w = 16'($urandom());
      if (w == sphlb_pkg::SYNC_MARK) w = w ^ 16'h0001;
      send(word_beat(w));
    end
    send(word_beat(sphlb_pkg::SYNC_MARK));
    if ($urandom_range(9, 0) == 0) send(xfer_beat(pick_count(sb.budget), 1'($urandom())));
    w = 16'($urandom());
    if ($urandom_range(3, 0) != 0) w[7:0] = code;
    send(word_beat(w));
    send(word_beat(pick_length(lim)));
    send(word_beat(pick_length(lim)));
    repeat ($urandom_range(6, 0))
      send(xfer_beat(pick_count(sb.budget), $urandom_range(4, 0) == 0));
  endtask

  // Noise: stray header words, stray transfers or anything at all
  task automatic send_noise();
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(2, 0))
        0: send(random_beat());
        1: send(word_beat(16'($urandom())));
        default: send(xfer_beat(16'($urandom()), 1'($urandom())));
      endcase
    end
  endtask

  // Random phase with one long result hold and one full drain along the way
  task automatic run_phase(int unsigned n_items);
    int unsigned start;
    logic        held;
    logic        paused;
    start  = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9, 0) == 0) send_noise();
      else send_packet();
      if (!held && items_sent - start > n_items / 3) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
      if (!paused && items_sent - start > 2 * n_items / 3) begin
        drain();
        burst_left = 0;
        paused     = 1'b1;
      end
    end
    drain();
  endtask

  // Directed opening: idle and unlimited cases, clamping, padding, mismatch
  task automatic run_directed();
    send(word_beat(sphlb_pkg::SYNC_MARK));
    send(unused_beat());
    send(xfer_beat(16'hFFFF, 1'b0));
    send(xfer_beat(16'h0123, 1'b1));
    send(open_beat(1'b0, 8'hA5, 1'b0));
    send(word_beat(16'h0000));
    send(word_beat(16'hFFFF));
    send(word_beat(sphlb_pkg::SYNC_MARK));
    send(word_beat(16'hFFA5));
    send(word_beat(16'hFFFF));
    send(word_beat(16'h0000));
    send(xfer_beat(16'd0, 1'b0));
    send(xfer_beat(16'd100, 1'b0));
    send(xfer_beat(16'hFFFF, 1'b0));
    send(xfer_beat(16'd5, 1'b1));
    send(open_beat(1'b1, 8'h00, 1'b1));
    send(word_beat(sphlb_pkg::SYNC_MARK));
    send(word_beat(16'h1234));
    send(word_beat(16'd3));
    send(word_beat(16'd4));
    send(open_beat(1'b1, 8'h5A, 1'b0));
    send(word_beat(sphlb_pkg::SYNC_MARK));
    send(word_beat(16'h00FF));
    send(word_beat(16'd20480));
    send(word_beat(16'd20000));
    send(open_beat(1'b0, 8'h3C, 1'b0));
    send(word_beat(sphlb_pkg::SYNC_MARK));
    send(xfer_beat(16'd7, 1'b1));
    drain();
  endtask

  initial begin : stimulus
    int unsigned lim_first[5];
    int unsigned lim_second[5];
    int unsigned miss_lims[5];
    int unsigned gaps[5];
    sb           = new();
    rst_n        = 1'b0;
    req_valid    = 1'b0;
    req_beat     = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    hold_request = 1'b0;
    items_sent   = 0;
    burst_left   = 0;
    max_gap      = 8;

    // Settings per phase, extremes first
    lim_first  = '{0, 32767, 5, $urandom_range(32767, 0), 40};
    lim_second = '{32767, 0, 100, $urandom_range(32767, 0), 1000};
    miss_lims  = '{1, 16383, 3, $urandom_range(8, 1), 0};
    gaps       = '{4, 0, 8, 3, 2};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    run_phase(ITEMS_PER_PHASE);

    for (int p = 0; p < 5; p++) begin
      write_reg(sphlb_pkg::REG_LIMIT_FIRST, lim_first[p]);
      write_reg(sphlb_pkg::REG_LIMIT_SECOND, lim_second[p]);
      write_reg(sphlb_pkg::REG_MISS_LIMIT, miss_lims[p]);
      max_gap    = gaps[p];
      burst_left = 0;
      run_phase(ITEMS_PER_PHASE);
    end

    drain();
    repeat (5) @(negedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("spi_packet_header_and_length_budget: match");
    end else begin
      $display("spi_packet_header_and_length_budget: mismatch");
    end
    $finish;
  end

endmodule
